FILE: rtl/core/cfpc_pkg.sv
// Shared types, constants and a helper function for the cube face projection and cull block.
package cfpc_pkg;

    // Default module parameters.
    localparam int DEF_CENTER_X = 320;
    localparam int DEF_CENTER_Y = 240;
    localparam int DEF_MAP_SIDE = 64;

    // Result field widths.
    localparam int COORD_W = 20;
    localparam int QUAD_W  = 9 * COORD_W;
    localparam int TDATA_W = ((QUAD_W + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SIN_YAW    = 3'd0,
        CFG_COS_YAW    = 3'd1,
        CFG_SIN_PITCH  = 3'd2,
        CFG_COS_PITCH  = 3'd3,
        CFG_CELL_SCALE = 3'd4,
        CFG_CAM_X      = 3'd5,
        CFG_CAM_Z      = 3'd6
    } t_cfg_reg;

    // Face codes carried on the result channel.
    typedef enum logic [2:0] {
        FACE_FLOOR = 3'd0,
        FACE_NORTH = 3'd1,
        FACE_EAST  = 3'd2,
        FACE_SOUTH = 3'd3,
        FACE_WEST  = 3'd4,
        FACE_TOP   = 3'd5
    } t_face;

    // Camera and cube configuration.
    typedef struct packed {
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_pitch;
        logic signed [15:0] cos_pitch;
        logic        [11:0] cell_scale;
        logic        [17:0] cam_x;
        logic        [17:0] cam_z;
    } t_cfg;

    // Corner offsets, bit k belongs to corner k.
    localparam logic [7:0] CORNER_DX = 8'b0110_0110;
    localparam logic [7:0] CORNER_DY = 8'b1100_1100;
    localparam logic [7:0] CORNER_DZ = 8'b1111_0000;

    typedef logic [2:0] t_cidx;

    // Quad corner lists: floor first, then the wall faces in emission order.
    localparam t_cidx QUAD_CORNER [6][4] = '{
        '{3'd4, 3'd0, 3'd1, 3'd5},
        '{3'd3, 3'd0, 3'd1, 3'd2},
        '{3'd6, 3'd5, 3'd4, 3'd7},
        '{3'd7, 3'd4, 3'd0, 3'd3},
        '{3'd2, 3'd1, 3'd5, 3'd6},
        '{3'd7, 3'd3, 3'd2, 3'd6}
    };

    localparam t_face QUAD_FACE [6] = '{
        FACE_FLOOR, FACE_SOUTH, FACE_NORTH, FACE_EAST, FACE_WEST, FACE_TOP
    };

    // Saturate a signed value to the 20 bit result range.
    function automatic logic [19:0] sat20(input logic signed [25:0] v);
        if (v > 26'sd524287) begin
            return 20'h7FFFF;
        end else if (v < -26'sd524288) begin
            return 20'h80000;
        end
        return v[19:0];
    endfunction

endpackage

FILE: rtl/core/cfpc_xform.sv
// Five-stage pipeline that translates and rotates the eight corners of one cube.
module cfpc_xform (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [5:0]            i_col,
    input  logic [5:0]            i_row,
    input  cfpc_pkg::t_cfg        i_cfg,
    output logic signed [21:0]    o_rx [8],
    output logic signed [23:0]    o_wy [8],
    output logic signed [23:0]    o_wz [8]
);

    // Stage 1: world position relative to the camera.
    logic signed [19:0] r_x [2];
    logic signed [19:0] r_z [2];
    logic signed [12:0] r_y;
    logic        [17:0] n_cs;
    logic        [17:0] n_rs;
    logic signed [19:0] n_x0;
    logic signed [19:0] n_z0;

    always_comb begin
        n_cs = {12'b0, i_col} * {6'b0, i_cfg.cell_scale};
        n_rs = {12'b0, i_row} * {6'b0, i_cfg.cell_scale};
        n_x0 = $signed({2'b0, n_cs}) - $signed({2'b0, i_cfg.cam_x});
        n_z0 = $signed({2'b0, n_rs}) - $signed({2'b0, i_cfg.cam_z});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_x[1] <= n_x0 + $signed({8'b0, i_cfg.cell_scale});
            r_z[0] <= n_z0;
            r_z[1] <= n_z0 + $signed({8'b0, i_cfg.cell_scale});
            r_y    <= -$signed({1'b0, i_cfg.cell_scale});
        end
    end

    // Stage 2: yaw products.
    logic signed [35:0] r_xc [2];
    logic signed [35:0] r_xs [2];
    logic signed [35:0] r_zc [2];
    logic signed [35:0] r_zs [2];
    logic signed [12:0] r_t2_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int d = 0; d < 2; d++) begin
                r_xc[d] <= r_x[d] * i_cfg.cos_yaw;
                r_xs[d] <= r_x[d] * i_cfg.sin_yaw;
                r_zc[d] <= r_z[d] * i_cfg.cos_yaw;
                r_zs[d] <= r_z[d] * i_cfg.sin_yaw;
            end
            r_t2_y <= r_y;
        end
    end

    // Stage 3: yaw sums with rounding, one per (dx, dz) pair.
    logic signed [35:0] n_rxs [4];
    logic signed [35:0] n_rzs [4];
    logic signed [21:0] r_rx [4];
    logic signed [21:0] r_rz [4];
    logic signed [12:0] r_t3_y;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_rxs[j] = r_xc[j % 2] + r_zs[j / 2] + 36'sd8192;
            n_rzs[j] = r_zc[j / 2] - r_xs[j % 2] + 36'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_rx[j] <= n_rxs[j][35:14];
                r_rz[j] <= n_rzs[j][35:14];
            end
            r_t3_y <= r_t2_y;
        end
    end

    // Stage 4: pitch products.
    logic signed [37:0] r_rzsp [4];
    logic signed [37:0] r_rzcp [4];
    logic signed [21:0] r_t4_rx [4];
    logic signed [28:0] r_ycp;
    logic signed [28:0] r_ysp;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 4; j++) begin
                r_rzsp[j]  <= r_rz[j] * i_cfg.sin_pitch;
                r_rzcp[j]  <= r_rz[j] * i_cfg.cos_pitch;
                r_t4_rx[j] <= r_rx[j];
            end
            r_ycp <= r_t3_y * i_cfg.cos_pitch;
            r_ysp <= r_t3_y * i_cfg.sin_pitch;
        end
    end

    // Stage 5: pitch sums with rounding for each corner.
    logic signed [39:0] n_wy [8];
    logic signed [39:0] n_wz [8];
    logic signed [21:0] r_rx5 [8];
    logic signed [23:0] r_wy [8];
    logic signed [23:0] r_wz [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_wy[k] = (cfpc_pkg::CORNER_DY[k] ? 40'(r_ycp) : 40'sd0)
                      - 40'(r_rzsp[{cfpc_pkg::CORNER_DZ[k], cfpc_pkg::CORNER_DX[k]}])
                      + 40'sd8192;
            n_wz[k] = (cfpc_pkg::CORNER_DY[k] ? 40'(r_ysp) : 40'sd0)
                      + 40'(r_rzcp[{cfpc_pkg::CORNER_DZ[k], cfpc_pkg::CORNER_DX[k]}])
                      + 40'sd8192;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 8; k++) begin
                r_wy[k]  <= n_wy[k][37:14];
                r_wz[k]  <= n_wz[k][37:14];
                r_rx5[k] <= r_t4_rx[{cfpc_pkg::CORNER_DZ[k], cfpc_pkg::CORNER_DX[k]}];
            end
        end
    end

    assign o_rx = r_rx5;
    assign o_wy = r_wy;
    assign o_wz = r_wz;

endmodule

FILE: rtl/core/cube_face_project_cull.sv
// Top level: orthographic projection and back-face culling of map cells into screen quads.
//
// Usage:
// The slave stream takes one map cell per transfer: tdata holds cell_col and cell_row,
// tuser holds the wall flag. For each cell the master stream delivers zero to five quads,
// one per transfer, with the face code in tuser, the corners and mean depth in tdata,
// and tlast on the final quad of the cell. A cell with no visible face yields nothing.
// The configuration channel writes camera and cube registers by index; it is always
// ready and must only be used while no cell is in flight.
// Path: a cell passes through eight register stages, the first of which takes the input
// transfer: five transform stages, a cull stage, a quad holding stage and the output
// register, which offers the cell's first quad on the master side.
// Throughput: one cell per cycle when it yields at most one quad and the receiver is ready;
// a cell with n quads stays in the quad holding stage while the output takes one a cycle.
// Synchronous reset empties the pipeline and loads the default camera registers.
// When the receiver stalls, the output register holds its quad and the pipeline stops
// behind the holding stage; nothing is lost or repeated.
module cube_face_project_cull #(
    parameter int CENTER_X = cfpc_pkg::DEF_CENTER_X,
    parameter int CENTER_Y = cfpc_pkg::DEF_CENTER_Y,
    parameter int MAP_SIDE = cfpc_pkg::DEF_MAP_SIDE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [15:0]                  i_s_axis_tdata,  // cell_col, cell_row, zero pad
    input  logic                         i_s_axis_tuser,  // is_wall
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, mean_depth, zero pad
    output logic [cfpc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [2:0]                   o_m_axis_tuser,  // face_code
    output logic                         o_m_axis_tlast,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [2:0]                   i_cfg_index,
    input  logic [17:0]                  i_cfg_data
);

    localparam int QW = cfpc_pkg::QUAD_W;

    // Configuration registers.
    cfpc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_yaw    <= 16'sd0;
            r_cfg.cos_yaw    <= 16'sd16384;
            r_cfg.sin_pitch  <= -16'sd11559;
            r_cfg.cos_pitch  <= 16'sd11612;
            r_cfg.cell_scale <= 12'd256;
            r_cfg.cam_x      <= 18'd0;
            r_cfg.cam_z      <= 18'd0;
        end else if (i_cfg_valid) begin
            unique case (cfpc_pkg::t_cfg_reg'(i_cfg_index))
                cfpc_pkg::CFG_SIN_YAW:    r_cfg.sin_yaw    <= i_cfg_data[15:0];
                cfpc_pkg::CFG_COS_YAW:    r_cfg.cos_yaw    <= i_cfg_data[15:0];
                cfpc_pkg::CFG_SIN_PITCH:  r_cfg.sin_pitch  <= i_cfg_data[15:0];
                cfpc_pkg::CFG_COS_PITCH:  r_cfg.cos_pitch  <= i_cfg_data[15:0];
                cfpc_pkg::CFG_CELL_SCALE: r_cfg.cell_scale <= i_cfg_data[11:0];
                cfpc_pkg::CFG_CAM_X:      r_cfg.cam_x      <= i_cfg_data;
                cfpc_pkg::CFG_CAM_Z:      r_cfg.cam_z      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything before the holding stage moves together.
    logic en;
    logic [5:0] col_in;
    logic [5:0] row_in;
    logic wall_in;

    assign o_s_axis_tready = en;
    assign col_in  = i_s_axis_tdata[5:0];
    assign row_in  = i_s_axis_tdata[11:6];
    assign wall_in = i_s_axis_tuser && ({5'b0, col_in} < 11'(MAP_SIDE))
                     && ({5'b0, row_in} < 11'(MAP_SIDE));

    // Valid and wall flags travel beside the transform stages.
    logic [4:0] r_v;
    logic [4:0] r_wall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wall <= {r_wall[3:0], wall_in};
        end
    end

    // Transform of the cell's cube and of the reference cube at the origin cell.
    logic signed [21:0] c_rx [8];
    logic signed [23:0] c_wy [8];
    logic signed [23:0] c_wz [8];
    logic signed [21:0] f_rx [8];
    logic signed [23:0] f_wy [8];
    logic signed [23:0] f_wz [8];

    cfpc_xform u_cube (
        .i_clk (i_clk),
        .i_en  (en),
        .i_col (col_in),
        .i_row (row_in),
        .i_cfg (r_cfg),
        .o_rx  (c_rx),
        .o_wy  (c_wy),
        .o_wz  (c_wz)
    );

    cfpc_xform u_ref (
        .i_clk (i_clk),
        .i_en  (en),
        .i_col (6'd0),
        .i_row (6'd0),
        .i_cfg (r_cfg),
        .o_rx  (f_rx),
        .o_wy  (f_wy),
        .o_wz  (f_wz)
    );

    // Cull stage: cross products on the reference cube, screen quads from the cell cube.
    logic signed [24:0] n_ux [6];
    logic signed [24:0] n_uy [6];
    logic signed [24:0] n_vx [6];
    logic signed [24:0] n_vy [6];
    logic [19:0]        n_sx [8];
    logic [19:0]        n_sy [8];
    logic signed [25:0] n_zs [6];
    logic [QW-1:0]      n_quad [6];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_sx[k] = cfpc_pkg::sat20(26'(c_rx[k]) + 26'(16 * CENTER_X));
            n_sy[k] = cfpc_pkg::sat20(26'(c_wy[k]) + 26'(16 * CENTER_Y));
        end
        for (int q = 0; q < 6; q++) begin
            n_ux[q] = 25'(f_rx[cfpc_pkg::QUAD_CORNER[q][1]])
                      - 25'(f_rx[cfpc_pkg::QUAD_CORNER[q][0]]);
            n_uy[q] = 25'(f_wy[cfpc_pkg::QUAD_CORNER[q][1]])
                      - 25'(f_wy[cfpc_pkg::QUAD_CORNER[q][0]]);
            n_vx[q] = 25'(f_rx[cfpc_pkg::QUAD_CORNER[q][2]])
                      - 25'(f_rx[cfpc_pkg::QUAD_CORNER[q][0]]);
            n_vy[q] = 25'(f_wy[cfpc_pkg::QUAD_CORNER[q][2]])
                      - 25'(f_wy[cfpc_pkg::QUAD_CORNER[q][0]]);
            n_zs[q] = 26'(c_wz[cfpc_pkg::QUAD_CORNER[q][0]])
                      + 26'(c_wz[cfpc_pkg::QUAD_CORNER[q][1]])
                      + 26'(c_wz[cfpc_pkg::QUAD_CORNER[q][2]])
                      + 26'(c_wz[cfpc_pkg::QUAD_CORNER[q][3]]) + 26'sd2;
            n_quad[q] = {cfpc_pkg::sat20(26'($signed(n_zs[q][25:2]))),
                         n_sy[cfpc_pkg::QUAD_CORNER[q][3]], n_sx[cfpc_pkg::QUAD_CORNER[q][3]],
                         n_sy[cfpc_pkg::QUAD_CORNER[q][2]], n_sx[cfpc_pkg::QUAD_CORNER[q][2]],
                         n_sy[cfpc_pkg::QUAD_CORNER[q][1]], n_sx[cfpc_pkg::QUAD_CORNER[q][1]],
                         n_sy[cfpc_pkg::QUAD_CORNER[q][0]], n_sx[cfpc_pkg::QUAD_CORNER[q][0]]};
        end
    end

    logic               r_t6_valid;
    logic               r_t6_wall;
    logic signed [49:0] r_p1 [6];
    logic signed [49:0] r_p2 [6];
    logic [QW-1:0]      r_t6_quad [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t6_valid <= 1'b0;
        end else if (en) begin
            r_t6_valid <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t6_wall <= r_wall[4];
            for (int q = 0; q < 6; q++) begin
                r_p1[q]      <= n_ux[q] * n_vy[q];
                r_p2[q]      <= n_uy[q] * n_vx[q];
                r_t6_quad[q] <= n_quad[q];
            end
        end
    end

    // Visible face mask: floor only for floor cells, the five wall faces for walls.
    logic signed [50:0] n_cross [6];
    logic [5:0]         n_mask;

    always_comb begin
        for (int q = 0; q < 6; q++) begin
            n_cross[q] = 51'(r_p1[q]) - 51'(r_p2[q]);
        end
        n_mask[0] = (n_cross[0] > 51'sd0) && !r_t6_wall;
        for (int q = 1; q < 6; q++) begin
            n_mask[q] = (n_cross[q] > 51'sd0) && r_t6_wall;
        end
    end

    // Quad holding stage: hands out the visible quads one per cycle unless the output stalls.
    logic          r_e_valid;
    logic [5:0]    r_e_mask;
    logic [QW-1:0] r_e_quad [6];
    logic [2:0]    n_pick;
    logic [5:0]    n_rest;
    logic          n_e_last;
    logic          o_load;

    always_comb begin
        n_pick = 3'd0;
        for (int q = 5; q >= 0; q--) begin
            if (r_e_mask[q]) begin
                n_pick = 3'(q);
            end
        end
        n_rest   = r_e_mask & ~(6'd1 << n_pick);
        n_e_last = (n_rest == 6'd0);
    end

    assign o_load = r_e_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign en     = !r_e_valid || (o_load && n_e_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_mask  <= '0;
        end else if (en) begin
            r_e_valid <= r_t6_valid && (n_mask != 6'd0);
            r_e_mask  <= n_mask;
        end else if (o_load) begin
            r_e_mask  <= n_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_quad <= r_t6_quad;
        end
    end

    // Output register.
    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            o_m_axis_tdata <= {(cfpc_pkg::TDATA_W - QW)'(0), r_e_quad[n_pick]};
            o_m_axis_tuser <= cfpc_pkg::QUAD_FACE[n_pick];
            o_m_axis_tlast <= n_e_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;

`ifndef SYNTHESIS
    // A floor quad is always the only quad of its cell.
    a_floor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == cfpc_pkg::FACE_FLOOR) |-> o_m_axis_tlast)
        else $error("floor quad without last marker");

    // The holding stage never keeps an item with nothing left to send.
    a_hold_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e_mask != 6'd0))
        else $error("holding stage valid with empty face mask");

    // Reset empties the output.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // New input is refused while a multi-quad cell is still being handed out.
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && !n_e_last) |-> !o_s_axis_tready)
        else $error("input accepted while quads remain");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for cube_face_project_cull: predicted screen quads against the stream.
`timescale 1ns / 100ps

module testbench;

    localparam int  CYCLE_LIMIT = 300000;
    localparam int  DRAIN_CYCLES = 24;
    localparam int  HOLD_CYCLES = 300;
    localparam int  CX16 = 16 * cfpc_pkg::DEF_CENTER_X;
    localparam int  CY16 = 16 * cfpc_pkg::DEF_CENTER_Y;

    typedef struct {
        logic [5:0] col;
        logic [5:0] row;
        logic       wall;
    } t_cell;

    // Coordinate slots 0..7 are p0_x..p3_y, slot 8 is the mean depth.
    typedef struct {
        logic [2:0]  face;
        logic [19:0] coord[9];
        logic        last;
    } t_quad;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         o_s_axis_tready;
    logic [15:0]                  s_data = '0;
    logic                         s_user = 1'b0;
    logic                         o_m_axis_tvalid;
    logic                         m_ready = 1'b0;
    logic [cfpc_pkg::TDATA_W-1:0] o_m_axis_tdata;
    logic [2:0]                   o_m_axis_tuser;
    logic                         o_m_axis_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [2:0]                   cfg_index = '0;
    logic [17:0]                  cfg_data = '0;

    cube_face_project_cull dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Local copy of the camera registers.
    longint sin_y = 0, cos_y = 16384, sin_p = -11559, cos_p = 11612;
    longint side = 256, cam_x = 0, cam_z = 0;

    t_cell  cell_queue[$];
    t_quad  quad_queue[$];
    t_cell  cell_hold;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_req = 1'b0;
    bit     hold_seen = 1'b0;
    int     hold_cnt = 0;
    int     errors = 0;
    int     cycles = 0;

    function automatic longint sat20(longint v);
        if (v > 524287) begin
            return 524287;
        end else if (v < -524288) begin
            return -524288;
        end
        return v;
    endfunction

    // Rotate the eight corners of the cube at (col, row); >>> gives floor division.
    task automatic rotate_corners(input longint col, input longint row,
                                  output longint px[8], output longint py[8],
                                  output longint pz[8]);
        longint wx, wy, wz, rx, rz;
        for (int k = 0; k < 8; k++) begin
            wx = col * side + (cfpc_pkg::CORNER_DX[k] ? side : 0) - cam_x;
            wy = cfpc_pkg::CORNER_DY[k] ? -side : 0;
            wz = row * side + (cfpc_pkg::CORNER_DZ[k] ? side : 0) - cam_z;
            rx = (wx * cos_y + wz * sin_y + 8192) >>> 14;
            rz = (wz * cos_y - wx * sin_y + 8192) >>> 14;
            px[k] = rx;
            py[k] = (wy * cos_p - rz * sin_p + 8192) >>> 14;
            pz[k] = (wy * sin_p + rz * cos_p + 8192) >>> 14;
        end
    endtask

    function automatic bit face_visible(longint px[8], longint py[8], int a, int b, int d);
        longint ux, uy, vx, vy;
        ux = px[b] - px[a];
        uy = py[b] - py[a];
        vx = px[d] - px[a];
        vy = py[d] - py[a];
        return ux * vy - uy * vx > 0;
    endfunction

    // Visibility is judged on the cube at cell (0,0); coordinates come from the real cell.
    task automatic predict_quads(t_cell c);
        longint rx[8], ry[8], rz[8], qx[8], qy[8], qz[8];
        longint zsum;
        t_quad  q;
        int     first, top, n0, idx;
        rotate_corners(0, 0, rx, ry, rz);
        rotate_corners(c.col, c.row, qx, qy, qz);
        first = c.wall ? 1 : 0;
        top = c.wall ? 5 : 0;
        n0 = quad_queue.size();
        for (int f = first; f <= top; f++) begin
            if (face_visible(rx, ry, cfpc_pkg::QUAD_CORNER[f][0], cfpc_pkg::QUAD_CORNER[f][1],
                             cfpc_pkg::QUAD_CORNER[f][2])) begin
                zsum = 0;
                q.face = cfpc_pkg::QUAD_FACE[f];
                for (int k = 0; k < 4; k++) begin
                    idx = cfpc_pkg::QUAD_CORNER[f][k];
                    q.coord[2 * k] = 20'(sat20(qx[idx] + CX16));
                    q.coord[2 * k + 1] = 20'(sat20(qy[idx] + CY16));
                    zsum += qz[idx];
                end
                q.coord[8] = 20'(sat20((zsum + 2) >>> 2));
                q.last = 1'b0;
                quad_queue = {quad_queue, q};
            end
        end
        if (quad_queue.size() > n0) begin
            quad_queue[quad_queue.size() - 1].last = 1'b1;
        end
    endtask

    // Cell driver: predicts on each accepted transfer, then offers the next cell.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                predict_quads(cell_hold);
            end
            if (!s_valid || o_s_axis_tready) begin
                if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cell_hold = cell_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data <= {4'b0, cell_hold.row, cell_hold.col};
                    s_user <= cell_hold.wall;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Quad receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Quad monitor: each transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_quad q;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (quad_queue.size() == 0) begin
                $display("%0t: unexpected quad, expected none, actual face %0d tdata %h",
                         $time, o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                q = quad_queue.pop_front();
                if (o_m_axis_tuser !== q.face) begin
                    $display("%0t: face mismatch, expected %0d, actual %0d",
                             $time, q.face, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tlast !== q.last) begin
                    $display("%0t: tlast mismatch, expected %0b, actual %0b",
                             $time, q.last, o_m_axis_tlast);
                    errors++;
                end
                for (int k = 0; k < 9; k++) begin
                    if (o_m_axis_tdata[k * 20 +: 20] !== q.coord[k]) begin
                        $display("%0t: coordinate %0d mismatch, expected %h, actual %h",
                                 $time, k, q.coord[k], o_m_axis_tdata[k * 20 +: 20]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Register write; the local copy follows the same truncation as the block.
    task automatic write_reg(cfpc_pkg::t_cfg_reg idx, logic [17:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            cfpc_pkg::CFG_SIN_YAW:    sin_y = longint'($signed(value[15:0]));
            cfpc_pkg::CFG_COS_YAW:    cos_y = longint'($signed(value[15:0]));
            cfpc_pkg::CFG_SIN_PITCH:  sin_p = longint'($signed(value[15:0]));
            cfpc_pkg::CFG_COS_PITCH:  cos_p = longint'($signed(value[15:0]));
            cfpc_pkg::CFG_CELL_SCALE: side = longint'(value[11:0]);
            cfpc_pkg::CFG_CAM_X:      cam_x = longint'(value);
            cfpc_pkg::CFG_CAM_Z:      cam_z = longint'(value);
            default: ;
        endcase
    endtask

    // Waits until every cell is sent and every quad seen, then lets the pipeline settle.
    task automatic wait_drained();
        while (cell_queue.size() > 0 || s_valid || quad_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cell(int col, int row, bit wall);
        t_cell c;
        c.col = 6'(col);
        c.row = 6'(row);
        c.wall = wall;
        cell_queue = {cell_queue, c};
    endtask

    // Sine and cosine pairs in Q1.14, axis-aligned extremes included.
    localparam int ANGLES[8][2] = '{
        '{0, 16384}, '{16384, 0}, '{-16384, 0}, '{0, -16384},
        '{11585, 11585}, '{-6270, 15137}, '{15137, -6270}, '{-11559, 11612}
    };

    initial begin
        int a;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cells under the default camera: map corners, floors and walls.
        add_cell(0, 0, 0);
        add_cell(0, 0, 1);
        add_cell(63, 0, 1);
        add_cell(0, 63, 1);
        add_cell(63, 63, 1);
        add_cell(63, 63, 0);
        add_cell(21, 42, 1);
        add_cell(42, 21, 0);
        wait_drained();

        // Largest cube and camera far away: saturated screen coordinates.
        write_reg(cfpc_pkg::CFG_CELL_SCALE, 18'd4095);
        write_reg(cfpc_pkg::CFG_CAM_X, 18'h3FFFF);
        write_reg(cfpc_pkg::CFG_CAM_Z, 18'h3FFFF);
        add_cell(0, 0, 1);
        add_cell(63, 63, 1);
        add_cell(0, 0, 0);
        wait_drained();
        write_reg(cfpc_pkg::CFG_CAM_X, 18'd0);
        write_reg(cfpc_pkg::CFG_SIN_PITCH, 18'h3C000);
        write_reg(cfpc_pkg::CFG_COS_PITCH, 18'd0);
        add_cell(63, 0, 1);
        add_cell(5, 9, 0);
        wait_drained();

        // Collapsed cube: nothing visible, nothing emitted.
        write_reg(cfpc_pkg::CFG_CELL_SCALE, 18'd0);
        add_cell(10, 20, 1);
        add_cell(30, 40, 0);
        wait_drained();

        // Out-of-range register values are used as given.
        write_reg(cfpc_pkg::CFG_CELL_SCALE, 18'd300);
        write_reg(cfpc_pkg::CFG_SIN_YAW, 18'h08000);
        write_reg(cfpc_pkg::CFG_COS_YAW, 18'h3FFFF);
        add_cell(3, 7, 1);
        add_cell(7, 3, 0);
        wait_drained();

        // Random phases, each under its own camera and idling mode.
        for (int p = 0; p < 4; p++) begin
            a = $urandom_range(7);
            write_reg(cfpc_pkg::CFG_SIN_YAW, 18'(ANGLES[a][0]));
            write_reg(cfpc_pkg::CFG_COS_YAW, 18'(ANGLES[a][1]));
            a = $urandom_range(7);
            write_reg(cfpc_pkg::CFG_SIN_PITCH, 18'(ANGLES[a][0]));
            write_reg(cfpc_pkg::CFG_COS_PITCH, 18'(ANGLES[a][1]));
            write_reg(cfpc_pkg::CFG_CELL_SCALE,
                      18'((p == 3) ? 4095 : $urandom_range(1, 400)));
            write_reg(cfpc_pkg::CFG_CAM_X, 18'($urandom_range(0, 262143)));
            write_reg(cfpc_pkg::CFG_CAM_Z, 18'($urandom_range(0, 262143)));
            send_idle_pct = (p == 1) ? 68 : ((p == 3) ? 17 : 0);
            recv_stall_pct = (p == 2) ? 68 : ((p == 3) ? 17 : 0);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < 23; i++) begin
                add_cell($urandom_range(63), $urandom_range(63), $urandom_range(99) < 75);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/cfpc_pkg.sv
rtl/core/cfpc_xform.sv
rtl/core/cube_face_project_cull.sv
test/testbench.sv
